### design/ppu_pkg.sv
// Shared types, constants and helper functions for the particle pool.
package ppu_pkg;

  localparam int unsigned PoolSize = 64;
  localparam int unsigned SlotW    = 6;
  localparam logic [17:0] PiQ16    = 18'd205887;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_EMIT   = 2'd1,
    OP_RENDER = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ROT_RATE  = 2'd0,
    REG_SPREAD_VX = 2'd1,
    REG_SPREAD_VY = 2'd2,
    REG_SPREAD_SZ = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_TICK,
    ST_RENDER,
    ST_DIV,
    ST_DRAIN
  } state_t;

  // Memory word: kinematics and appearance of one particle.
  localparam int unsigned KinW = 32 * 5;
  localparam int unsigned AppW = 32 + 32 + 31 + 31;

  // Saturate a 34-bit signed sum to signed 32 bits.
  function automatic logic [31:0] sat_s32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7fffffff;
    else if (v < -34'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Saturate a 50-bit signed sum to signed 32 bits.
  function automatic logic [31:0] sat_s50(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) r = 32'h7fffffff;
    else if (v < -50'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Floor of (f-32768)*spread/65536.
  function automatic logic signed [32:0] jit(input logic [15:0] f, input logic [31:0] s);
    logic signed [16:0] d;
    logic signed [49:0] p;
    d = $signed({1'b0, f}) - 17'sd32768;
    p = d * $signed({1'b0, s});
    return p[48:16];
  endfunction

  // (e*(65536-t)+b*t)>>16 for a narrow channel.
  function automatic logic [7:0] mix8(input logic [7:0] e, input logic [7:0] b,
                                      input logic [16:0] t);
    logic [25:0] s;
    s = e * (17'd65536 - t) + b * t;
    return s[23:16];
  endfunction

endpackage

### design/ppu_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
module ppu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### design/ppu_div.sv
// Radix-2 restoring divider: 17-bit quotient of (num<<16)/den, num < den.
module ppu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [30:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [16:0] quo
);
  import ppu_pkg::*;
  logic [31:0] rem;
  logic [30:0] dv;
  logic [4:0]  cnt;
  logic        run;
  logic [32:0] sh;

  assign sh = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'd15;
        rem <= {1'b0, num};
        dv  <= den;
        quo <= '0;
      end else if (run) begin
        if (sh >= {2'b0, dv}) begin
          rem <= 32'(sh - {2'b0, dv});
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= sh[31:0];
          quo <= {quo[15:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end
endmodule

### design/particle_pool_update.sv
// Top level of the particle pool: emit, tick and render over a 64-slot RAM pool.
// Emit keeps busy high for 1 cycle after the accepting edge while it writes the slot.
// Tick walks the pool reading one slot per cycle and writing it back after the read
// register and the product register stage. Render reads one slot per cycle while no
// division runs; each active, partly spent particle stalls the walk while a 16-step
// divider forms its life fraction. Results come one per cycle at most on out_valid
// with no back-pressure, and the last one passes through the hold and output registers
// and appears after busy has already dropped. Reset clears the active mask and slot
// pointer; no clearing pass is needed.
module particle_pool_update (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  op,
  input  logic [31:0] delta_time,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] base_vel_x,
  input  logic signed [31:0] base_vel_y,
  input  logic [30:0] life_span,
  input  logic [30:0] start_size,
  input  logic [30:0] final_size,
  input  logic [31:0] start_colour,
  input  logic [31:0] final_colour,
  input  logic [63:0] random_word,
  output logic        out_valid,
  output logic [5:0]  slot,
  output logic        alive,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] angle,
  output logic [30:0] draw_size,
  output logic [31:0] draw_colour,
  output logic        last
);
  import ppu_pkg::*;

  logic signed [31:0] rot_rate;
  logic [31:0] spread_vx, spread_vy, spread_sz;

  state_t state, state_next;
  logic [PoolSize-1:0] active;
  logic [SlotW-1:0] next_slot;
  logic [SlotW:0]   idx;
  logic [31:0]      dt;
  logic [63:0]      rw;
  logic             rd_vld;
  logic [SlotW-1:0] rd_slot;

  // Kinematics word: pos_x, pos_y, vel_x, vel_y, angle; appearance word in app RAM.
  logic            kin_we, app_we, tl_we;
  logic [SlotW-1:0] kin_wa, app_wa, tl_wa, raddr;
  logic [KinW-1:0] kin_wd, kin_rd;
  logic [AppW-1:0] app_wd, app_rd;
  logic [62:0]     tl_wd, tl_rd;

  ppu_ram #(.Width(KinW), .Depth(PoolSize)) u_kin (
    .clk, .we(kin_we), .waddr(kin_wa), .wdata(kin_wd), .raddr, .rdata(kin_rd));
  ppu_ram #(.Width(AppW), .Depth(PoolSize)) u_app (
    .clk, .we(app_we), .waddr(app_wa), .wdata(app_wd), .raddr, .rdata(app_rd));
  ppu_ram #(.Width(63), .Depth(PoolSize)) u_tl (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr, .rdata(tl_rd));

  // Read fields.
  logic signed [31:0] r_px, r_py, r_vx, r_vy, r_ang, r_tl;
  logic [30:0] r_life, r_sb, r_se;
  logic [31:0] r_cb, r_ce;
  assign {r_px, r_py, r_vx, r_vy, r_ang} = kin_rd;
  assign {r_cb, r_ce, r_sb, r_se, r_life} = {app_rd[AppW-1 -: 32], app_rd[AppW-33 -: 32],
                                            app_rd[61:31], app_rd[30:0], tl_rd[30:0]};
  assign r_tl = tl_rd[62:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_rate  <= '0;
      spread_vx <= '0;
      spread_vy <= '0;
      spread_sz <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROT_RATE:  rot_rate  <= cfg_data;
        REG_SPREAD_VX: spread_vx <= cfg_data;
        REG_SPREAD_VY: spread_vy <= cfg_data;
        REG_SPREAD_SZ: spread_sz <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick stage 1: register products of the slot just read.
  logic             t_vld;
  logic [SlotW-1:0] t_slot;
  logic signed [31:0] t_px, t_py, t_ang, t_tl;
  logic signed [64:0] t_mx, t_my, t_mr;
  logic [94:0]      t_kin_raw;

  // Render stage: divider and result register.
  logic        dv_go, dv_done;
  logic [16:0] dv_q, frac;
  logic [SlotW-1:0] pend_slot;

  ppu_div u_div (.clk, .rst, .go(dv_go), .num(r_tl[30:0]), .den(r_life),
                 .done(dv_done), .quo(dv_q));

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) begin
        case (op_t'(op))
          OP_TICK:   state_next = ST_TICK;
          OP_EMIT:   state_next = ST_EMIT;
          OP_RENDER: state_next = ST_RENDER;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_EMIT:   state_next = ST_IDLE;
      ST_TICK:   if (idx == 7'(PoolSize) && !rd_vld && !t_vld) state_next = ST_IDLE;
      ST_RENDER: if (rd_vld && active[rd_slot] && r_tl > 0 && r_life != 0
                     && r_tl < $signed({1'b0, r_life})) state_next = ST_DIV;
                 else if (rd_vld && rd_slot == SlotW'(PoolSize - 1)) state_next = ST_DRAIN;
      ST_DIV:    if (dv_done) state_next = (pend_slot == SlotW'(PoolSize - 1)) ? ST_DRAIN
                                                                               : ST_RENDER;
      ST_DRAIN:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Address walk: issue one read per cycle, paused while a division runs.
  logic issue;
  assign issue = ((state == ST_TICK) || (state == ST_RENDER && state_next == ST_RENDER))
                 && idx < 7'(PoolSize);
  assign raddr = idx[SlotW-1:0];

  logic [33:0] ang0;
  assign ang0 = rw[15:0] * PiQ16;

  // Latched emit inputs.
  logic signed [31:0] e_ox, e_oy, e_vx, e_vy;
  logic [30:0] e_life, e_ss, e_fs;
  logic [31:0] e_sc, e_fc;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      dt <= delta_time;
      rw <= random_word;
      e_ox <= origin_x; e_oy <= origin_y; e_vx <= base_vel_x; e_vy <= base_vel_y;
      e_life <= life_span; e_ss <= start_size; e_fs <= final_size;
      e_sc <= start_colour; e_fc <= final_colour;
    end
  end

  logic signed [33:0] e_jvx, e_jvy;
  assign e_jvx = 34'(e_vx) + 34'(jit(rw[31:16], spread_vx));
  assign e_jvy = 34'(e_vy) + 34'(jit(rw[47:32], spread_vy));

  logic signed [33:0] e_jsz;
  logic [30:0] e_szb;
  assign e_jsz = $signed({3'b0, e_ss}) + 34'(jit(rw[63:48], spread_sz));
  always_comb begin
    if (e_jsz < 0) e_szb = '0;
    else if (e_jsz > 34'sd2147483647) e_szb = 31'h7fffffff;
    else e_szb = e_jsz[30:0];
  end

  // Tick stage 2 results.
  logic signed [49:0] n_px, n_py;
  logic signed [33:0] n_tl;
  logic [31:0] n_ang;
  assign n_px  = 50'(t_px) + 50'($signed(t_mx[64:16]));
  assign n_py  = 50'(t_py) + 50'($signed(t_my[64:16]));
  assign n_ang = t_ang + t_mr[47:16];
  assign n_tl  = 34'(t_tl) - $signed({2'b0, dt});

  always_comb begin
    kin_we = 1'b0; app_we = 1'b0; tl_we = 1'b0;
    kin_wa = t_slot; app_wa = next_slot; tl_wa = t_slot;
    kin_wd = {sat_s50(n_px), sat_s50(n_py), t_kin_raw[94:31], n_ang};
    app_wd = {e_sc, e_fc, e_szb, e_fs};
    tl_wd  = {sat_s32(n_tl), t_kin_raw[30:0]};
    if (state == ST_EMIT) begin
      kin_we = 1'b1; app_we = 1'b1; tl_we = 1'b1;
      kin_wa = next_slot; tl_wa = next_slot;
      kin_wd = {e_ox, e_oy, sat_s32(e_jvx), sat_s32(e_jvy), {14'b0, ang0[33:16]}};
      tl_wd  = {1'b0, e_life, e_life};
    end else if (t_vld) begin
      kin_we = 1'b1; tl_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; rd_vld <= 1'b0; t_vld <= 1'b0;
      active <= '0; next_slot <= '0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        rd_slot <= raddr;
        idx <= idx + 7'd1;
      end
      if (state == ST_IDLE) idx <= '0;
      t_vld <= 1'b0;
      if (state == ST_EMIT) begin
        active[next_slot] <= 1'b1;
        next_slot <= (next_slot == SlotW'(PoolSize - 1)) ? '0 : next_slot + SlotW'(1);
      end
      if (state == ST_TICK && rd_vld && active[rd_slot]) begin
        if (r_tl <= 0) active[rd_slot] <= 1'b0;
        else t_vld <= 1'b1;
      end
    end
  end

  // Products registered before the accumulate stage.
  always_ff @(posedge clk) begin
    t_slot <= rd_slot;
    t_px <= r_px; t_py <= r_py; t_ang <= r_ang; t_tl <= r_tl;
    t_mx <= r_vx * $signed({1'b0, dt});
    t_my <= r_vy * $signed({1'b0, dt});
    t_mr <= rot_rate * $signed({1'b0, dt});
    t_kin_raw <= {r_vx, r_vy, r_life};
  end

  // Render: hold the slot data while the divider runs.
  logic signed [31:0] h_px, h_py, h_ang;
  logic [30:0] h_sb, h_se;
  logic [31:0] h_cb, h_ce;
  logic        h_alive, h_emit;
  logic [16:0] h_t;

  assign dv_go = (state == ST_RENDER) && (state_next == ST_DIV);

  always_comb begin
    if (r_tl <= 0 || r_life == 0) frac = '0;
    else frac = 17'd65536;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_emit <= 1'b0;
    end else begin
      h_emit <= 1'b0;
      if (state == ST_RENDER && rd_vld) begin
        pend_slot <= rd_slot;
        h_px <= r_px; h_py <= r_py; h_ang <= r_ang;
        h_sb <= r_sb; h_se <= r_se; h_cb <= r_cb; h_ce <= r_ce;
        h_alive <= active[rd_slot];
        h_t <= frac;
        h_emit <= !dv_go;
      end
      if (state == ST_DIV && dv_done) begin
        h_t <= dv_q; h_emit <= 1'b1;
      end
    end
  end

  // Output register.
  logic [47:0] sz_mix;
  assign sz_mix = h_se * (17'd65536 - h_t) + h_sb * h_t;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= h_emit;
    slot  <= pend_slot;
    last  <= (pend_slot == SlotW'(PoolSize - 1));
    alive <= h_alive;
    pos_x <= h_alive ? h_px : '0;
    pos_y <= h_alive ? h_py : '0;
    angle <= h_alive ? h_ang : '0;
    draw_size <= h_alive ? sz_mix[46:16] : '0;
    draw_colour <= h_alive ? {mix8(h_ce[31:24], h_cb[31:24], h_t),
                              mix8(h_ce[23:16], h_cb[23:16], h_t),
                              mix8(h_ce[15:8],  h_cb[15:8],  h_t),
                              mix8(h_ce[7:0],   h_cb[7:0],   h_t)} : '0;
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> $past(busy))
    else $error("result outside a render");
  assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> !issue)
    else $error("pool read issued during division");
  assert property (@(posedge clk) disable iff (rst)
                   (kin_we && state != ST_EMIT) |-> $past(state == ST_TICK, 1) || state == ST_TICK)
    else $error("write-back outside tick");
endmodule

### sim/tb_particle_pool_update.sv
// Self-checking testbench for the particle pool: emit, tick and render against a predictor.
module tb_particle_pool_update;
  timeunit 1ns;
  timeprecision 1ps;
  import ppu_pkg::*;

  typedef struct {
    op_t               op;
    logic [31:0]       dt;
    logic signed [31:0] ox, oy, vx, vy;
    logic [30:0]       life, ssize, fsize;
    logic [31:0]       scol, fcol;
    logic [63:0]       rnd;
  } request_t;

  typedef struct {
    logic [5:0]        slot;
    logic              alive;
    logic signed [31:0] px, py, ang;
    logic [30:0]       size;
    logic [31:0]       colour;
    logic              last;
  } slot_view_t;

  class pool_scoreboard;
    logic signed [31:0] rot_rate;
    logic [31:0]        spread_vx, spread_vy, spread_sz;
    bit                 live[64];
    logic signed [31:0] px[64], py[64], vx[64], vy[64], tleft[64], tlife[64];
    logic [31:0]        ang[64], sz_b[64], sz_e[64], col_b[64], col_e[64];
    int unsigned        head;
    slot_view_t         pending_views[$];
    int unsigned        errors, checked, n_emit, n_tick, n_render;

    function new();
      rot_rate = 0; spread_vx = 0; spread_vy = 0; spread_sz = 0;
      foreach (live[i]) live[i] = 0;
      head = 0; errors = 0; checked = 0; n_emit = 0; n_tick = 0; n_render = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_ROT_RATE:  rot_rate = v;
        REG_SPREAD_VX: spread_vx = v;
        REG_SPREAD_VY: spread_vy = v;
        REG_SPREAD_SZ: spread_sz = v;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function longint wobble(logic [15:0] f, logic [31:0] spread);
      longint p;
      p = (longint'({1'b0, f}) - 32768) * longint'({32'd0, spread});
      return p >>> 16;
    endfunction

    function longint unsigned blend(longint unsigned e, longint unsigned b,
                                    longint unsigned t);
      return (e * (65536 - t) + b * t) >> 16;
    endfunction

    function void note_request(request_t r);
      longint dt, s;
      longint unsigned t;
      logic [31:0] colour;
      slot_view_t v;
      dt = longint'({32'd0, r.dt});
      case (r.op)
        OP_TICK: begin
          n_tick++;
          for (int i = 0; i < 64; i++) begin
            if (!live[i]) continue;
            if (tleft[i] <= 0) begin
              live[i] = 0;
              continue;
            end
            px[i] = clip32(longint'(px[i]) + ((longint'(vx[i]) * dt) >>> 16));
            py[i] = clip32(longint'(py[i]) + ((longint'(vy[i]) * dt) >>> 16));
            s = (longint'(rot_rate) * dt) >>> 16;
            ang[i] = ang[i] + s[31:0];
            tleft[i] = clip32(longint'(tleft[i]) - dt);
          end
        end
        OP_EMIT: begin
          n_emit++;
          live[head] = 1;
          px[head] = r.ox;
          py[head] = r.oy;
          s = (longint'({1'b0, r.rnd[15:0]}) * 205887) >> 16;
          ang[head] = s[31:0];
          vx[head] = clip32(longint'(r.vx) + wobble(r.rnd[31:16], spread_vx));
          vy[head] = clip32(longint'(r.vy) + wobble(r.rnd[47:32], spread_vy));
          col_b[head] = r.scol;
          col_e[head] = r.fcol;
          tlife[head] = {1'b0, r.life};
          tleft[head] = {1'b0, r.life};
          s = longint'({1'b0, r.ssize}) + wobble(r.rnd[63:48], spread_sz);
          if (s < 0) s = 0;
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          sz_b[head] = s[31:0];
          sz_e[head] = {1'b0, r.fsize};
          head = (head + 1) % 64;
        end
        OP_RENDER: begin
          n_render++;
          for (int i = 0; i < 64; i++) begin
            v = '{default: '0};
            v.slot = 6'(i);
            v.last = (i == 63);
            if (live[i]) begin
              if (tleft[i] <= 0 || tlife[i] <= 0) t = 0;
              else if (tleft[i] >= tlife[i]) t = 65536;
              else t = (longint'(tleft[i]) << 16) / longint'(tlife[i]);
              for (int c = 0; c < 32; c += 8)
                colour[c +: 8] = 8'(blend(col_e[i][c +: 8], col_b[i][c +: 8], t));
              v.alive = 1;
              v.px = px[i];
              v.py = py[i];
              v.ang = ang[i];
              v.size = 31'(blend(sz_e[i], sz_b[i], t));
              v.colour = colour;
            end
            pending_views.push_back(v);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_slot(slot_view_t got);
      slot_view_t w;
      if (pending_views.size() == 0) begin
        $error("unexpected result for slot %0d", got.slot);
        errors++;
        return;
      end
      w = pending_views.pop_front();
      checked++;
      if (got.slot !== w.slot) begin
        $error("slot: expected %0d got %0d", w.slot, got.slot); errors++;
      end
      if (got.alive !== w.alive) begin
        $error("alive: expected %0d got %0d", w.alive, got.alive); errors++;
      end
      if (got.px !== w.px) begin
        $error("pos_x: expected %h got %h", w.px, got.px); errors++;
      end
      if (got.py !== w.py) begin
        $error("pos_y: expected %h got %h", w.py, got.py); errors++;
      end
      if (got.ang !== w.ang) begin
        $error("angle: expected %h got %h", w.ang, got.ang); errors++;
      end
      if (got.size !== w.size) begin
        $error("draw_size: expected %h got %h", w.size, got.size); errors++;
      end
      if (got.colour !== w.colour) begin
        $error("draw_colour: expected %h got %h", w.colour, got.colour); errors++;
      end
      if (got.last !== w.last) begin
        $error("last: expected %0d got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, busy, cfg_we = 0;
  logic [1:0] cfg_index = '0, op = '0;
  logic [31:0] cfg_data = '0, delta_time = '0, start_colour = '0, final_colour = '0;
  logic signed [31:0] origin_x = '0, origin_y = '0, base_vel_x = '0, base_vel_y = '0;
  logic [30:0] life_span = '0, start_size = '0, final_size = '0;
  logic [63:0] random_word = '0;
  logic out_valid, alive, last;
  logic [5:0] slot;
  logic signed [31:0] pos_x, pos_y, angle;
  logic [30:0] draw_size;
  logic [31:0] draw_colour;

  pool_scoreboard sb = new();

  particle_pool_update dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    slot_view_t got;
    if (!rst && out_valid) begin
      got.slot = slot; got.alive = alive; got.px = pos_x; got.py = pos_y;
      got.ang = angle; got.size = draw_size; got.colour = draw_colour; got.last = last;
      sb.check_slot(got);
    end
  end

  task automatic issue(request_t r);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    op <= r.op; delta_time <= r.dt; origin_x <= r.ox; origin_y <= r.oy;
    base_vel_x <= r.vx; base_vel_y <= r.vy; life_span <= r.life;
    start_size <= r.ssize; final_size <= r.fsize; start_colour <= r.scol;
    final_colour <= r.fcol; random_word <= r.rnd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
  endtask

  // Drain outstanding results and let the block settle before register writes.
  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (sb.pending_views.size() != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] rate, logic [31:0] sx, logic [31:0] sy,
                              logic [31:0] ss);
    reg_idx_t idx[4] = '{REG_ROT_RATE, REG_SPREAD_VX, REG_SPREAD_VY, REG_SPREAD_SZ};
    logic [31:0] val[4];
    val = '{rate, sx, sy, ss};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic request_t blank(op_t o);
    request_t r;
    r = '{op: o, default: '0};
    return r;
  endfunction

  function automatic request_t rand_emit(bit wide);
    request_t r;
    r = blank(OP_EMIT);
    r.rnd = {$urandom, $urandom};
    r.scol = $urandom;
    r.fcol = $urandom;
    if (wide) begin
      r.ox = $urandom; r.oy = $urandom; r.vx = $urandom; r.vy = $urandom;
      r.life = 31'($urandom); r.ssize = 31'($urandom); r.fsize = 31'($urandom);
    end else begin
      r.ox = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      r.oy = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      r.vx = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      r.vy = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      r.life = 31'($urandom_range(0, 32'h00040000));
      r.ssize = 31'($urandom_range(0, 32'h00100000));
      r.fsize = 31'($urandom_range(0, 32'h00100000));
    end
    return r;
  endfunction

  function automatic request_t rand_tick(bit wide);
    request_t r;
    r = blank(OP_TICK);
    r.dt = wide ? $urandom : $urandom_range(0, 32'h00008000);
    return r;
  endfunction

  initial begin
    request_t r;
    int unsigned pick, limit;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of fields and registers, zero life, unused op
    program_regs(32'h7fffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    r = blank(OP_EMIT);
    r.ox = 32'h7fffffff; r.oy = 32'h80000000; r.vx = 32'h7fffffff; r.vy = 32'h80000000;
    r.life = 31'h7fffffff; r.ssize = 31'h7fffffff; r.fsize = 31'h7fffffff;
    r.scol = 32'hffffffff; r.fcol = 32'h0; r.rnd = 64'hffffffffffffffff;
    issue(r);
    r = blank(OP_EMIT);
    r.ox = 32'h80000000; r.oy = 32'h7fffffff; r.vx = 32'h80000000; r.vy = 32'h7fffffff;
    r.life = 0; r.ssize = 0; r.fsize = 0; r.scol = 32'h0; r.fcol = 32'hffffffff;
    r.rnd = 64'h0;
    issue(r);
    r = rand_emit(0); r.rnd = 64'h8000800080008000; issue(r);
    issue(rand_emit(0));
    issue(blank(OP_RENDER));
    r = blank(OP_TICK); r.dt = 32'h00004000; issue(r);
    issue(blank(OP_RENDER));
    issue(blank(OP_NONE));
    r = blank(OP_TICK); r.dt = 32'hffffffff; issue(r);
    issue(blank(OP_RENDER));
    issue(blank(OP_TICK));
    issue(blank(OP_RENDER));

    // random phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: program_regs(32'h0, 32'h0, 32'h0, 32'h0);
        1: program_regs(32'h80000000, 32'h00010000, 32'h00020000, 32'h00008000);
        2: program_regs($urandom, $urandom, $urandom, $urandom);
        default: program_regs($urandom_range(0, 32'h00040000) - 32'h00020000,
                              $urandom_range(0, 32'h00040000),
                              $urandom_range(0, 32'h00040000),
                              $urandom_range(0, 32'h00040000));
      endcase
      limit = (ph == 3) ? 70 : 50;
      for (int n = 0; n < limit; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) r = rand_emit($urandom_range(0, 9) == 0);
        else if (pick < 82) r = rand_tick($urandom_range(0, 14) == 0);
        else if (pick < 97) r = blank(OP_RENDER);
        else begin
          r = rand_emit(1);
          r.op = OP_NONE;
        end
        issue(r);
      end
    end
    issue(blank(OP_RENDER));

    start <= 0;
    @(posedge clk);
    while (sb.pending_views.size() != 0 || busy) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d emits, %0d ticks, %0d renders; %0d slot reports checked",
             sb.n_emit, sb.n_tick, sb.n_render, sb.checked);
    if (sb.errors == 0 && sb.pending_views.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
design/ppu_pkg.sv
design/ppu_ram.sv
design/ppu_div.sv
design/particle_pool_update.sv
sim/tb_particle_pool_update.sv
